/* rtl/exclusion_clique_detector_assert.svh */
// Assertion macros shared by the RTL of the exclusion clique detector.
`ifndef EXCLUSION_CLIQUE_DETECTOR_ASSERT_SVH
`define EXCLUSION_CLIQUE_DETECTOR_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define ECD_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// When the trigger holds, the consequence must hold in the next cycle.
`define ECD_ASSERT_NEXT(label, clk, rst, trig, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/ecd_pkg.sv */
package ecd_pkg;

   localparam int VAR_COUNT   = 1024;
   localparam int CLAUSE_CAP  = 2048;
   localparam int NUM_NODES   = 2 * CLAUSE_CAP;
   localparam int VAR_W       = $clog2(VAR_COUNT);
   localparam int CL_W        = $clog2(CLAUSE_CAP);
   localparam int CNT_W       = CL_W + 1;
   localparam int NODE_W      = $clog2(NUM_NODES);
   localparam int LINK_W      = NODE_W + 1;
   localparam int LIT_W       = 12;
   localparam int QSIZE_W     = 11;
   localparam int QSIZE_MAX   = 2047;
   localparam int NEED_W      = 2 * QSIZE_W;
   localparam int NDATA_W     = CL_W + 1 + LINK_W;

   typedef enum logic [1:0] {
      REQ_ADD   = 2'd0,
      REQ_QUERY = 2'd1,
      REQ_READ  = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_FULL = 2'd1,
      STAT_SAT  = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_ADD_RD0,
      ST_ADD_WR0,
      ST_ADD_RD1,
      ST_ADD_WR1,
      ST_CLR_RD,
      ST_CLR_WR,
      ST_Q_START,
      ST_Q_HEAD,
      ST_Q_LINK,
      ST_Q_NODE,
      ST_Q_SEEN,
      ST_Q_NEED,
      ST_Q_VERD,
      ST_PROOF_RD,
      ST_PROOF_CAP,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [1:0]              req_type;
      logic signed [LIT_W-1:0] lit_a;
      logic signed [LIT_W-1:0] lit_b;
      logic                    first_lit;
      logic                    last_lit;
      logic [CL_W-1:0]         proof_index;
   } req_data_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [CL_W-1:0]  clause_index;
      logic [CNT_W-1:0] verdict_count;
      logic             verdict_valid;
      logic [CL_W-1:0]  proof_entry;
      logic [CNT_W-1:0] proof_total;
   } rsp_data_type;

   function automatic logic [LIT_W-1:0] lit_mag(input logic signed [LIT_W-1:0] lit);
      lit_mag = lit[LIT_W-1] ? (~lit + LIT_W'(1)) : lit;
   endfunction

   function automatic logic lit_ok(input logic signed [LIT_W-1:0] lit);
      logic [LIT_W-1:0] mag;
      mag = lit_mag(lit);
      lit_ok = (mag != '0) && (mag <= LIT_W'(VAR_COUNT));
   endfunction

   function automatic logic [VAR_W-1:0] lit_var(input logic signed [LIT_W-1:0] lit);
      logic [LIT_W-1:0] mag;
      mag = lit_mag(lit) - LIT_W'(1);
      lit_var = mag[VAR_W-1:0];
   endfunction

endpackage

/* rtl/exclusion_clique_detector.sv */
// Exclusion clique detector.
// Requests enter on req_valid/req_ready with a req_data_type payload; each
// request gives exactly one response on rsp_valid/rsp_ready.
// An add links one node per literal into its variable's list through
// ST_ADD_RD0, ST_ADD_WR0, ST_ADD_RD1 and ST_ADD_WR1, or is answered directly
// when the table is full or a literal is invalid. A query literal walks the
// list of its variable node by node through the node memory, with a seen-mark
// step for each node of matching polarity; an invalid literal skips the walk.
// A first literal first clears the marks set since the previous first
// literal. A proof read reads one proof entry; an unknown request is answered
// directly. One request is worked on at a time; req_ready is high only while
// idle, which starts at the same edge that loads the response.
// The response sits in an output register, so the next request is taken
// while a response still waits; a stalled receiver holds that response and
// the block stops only when a second response is ready.
// After reset the block sweeps its list heads and clause marks and takes no
// request until that sweep is done.
`include "exclusion_clique_detector_assert.svh"

module exclusion_clique_detector import ecd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data
);

   state_type state_ff, state_in;
   req_data_type req_ff, req_in;
   logic [CNT_W-1:0] init_cnt_ff, init_cnt_in;
   logic [CNT_W-1:0] clause_count_ff, clause_count_in;
   logic [CNT_W-1:0] pair_count_ff, pair_count_in;
   logic [CNT_W-1:0] dirty_cnt_ff, dirty_cnt_in;
   logic [CNT_W-1:0] clr_idx_ff, clr_idx_in;
   logic [QSIZE_W-1:0] qsize_ff, qsize_in;
   logic [LINK_W-1:0] link_ff, link_in;
   logic [CL_W-1:0] cl_ff, cl_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [1:0] status_ff, status_in;
   logic [CL_W-1:0] cidx_ff, cidx_in;
   logic [CNT_W-1:0] verdict_ff, verdict_in;
   logic vvalid_ff, vvalid_in;
   logic [CL_W-1:0] pentry_ff, pentry_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   logic [LINK_W-1:0] heads_mem [VAR_COUNT];
   logic [NDATA_W-1:0] node_mem [NUM_NODES];
   logic seen_mem [CLAUSE_CAP];
   logic [CL_W-1:0] dirty_mem [CLAUSE_CAP];
   logic [CL_W-1:0] proof_mem [CLAUSE_CAP];

   logic heads_we, node_we, seen_we, dirty_we, proof_we;
   logic [VAR_W-1:0] heads_waddr, heads_raddr;
   logic [LINK_W-1:0] heads_wdata, heads_rdata_ff;
   logic [NODE_W-1:0] node_waddr, node_raddr;
   logic [NDATA_W-1:0] node_wdata, node_rdata_ff;
   logic [CL_W-1:0] seen_waddr, seen_raddr;
   logic seen_wdata, seen_rdata_ff;
   logic [CL_W-1:0] dirty_waddr, dirty_raddr, dirty_wdata, dirty_rdata_ff;
   logic [CL_W-1:0] proof_waddr, proof_raddr, proof_wdata, proof_rdata_ff;

   logic [CL_W-1:0] cur_clause;
   logic [NODE_W-1:0] node0, node1;
   logic [NEED_W-1:0] need_prod;
   logic out_free;
   logic mark_set;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cur_clause = clause_count_ff[CL_W-1:0];
   assign node0 = {cur_clause, 1'b0};
   assign node1 = {cur_clause, 1'b1};
   assign need_prod = NEED_W'({{QSIZE_W{1'b0}}, qsize_ff} *
                              {{QSIZE_W{1'b0}}, qsize_ff - QSIZE_W'(1)});
   assign mark_set = (state_ff == ST_Q_SEEN) && !seen_rdata_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (init_cnt_ff == CNT_W'(CLAUSE_CAP - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_code_type'(req_data.req_type))
                  REQ_ADD: begin
                     if (clause_count_ff >= CNT_W'(CLAUSE_CAP)) begin
                        state_in = ST_RESP;
                     end else if (lit_ok(req_data.lit_a) && lit_ok(req_data.lit_b)) begin
                        state_in = ST_ADD_RD0;
                     end else begin
                        state_in = ST_RESP;
                     end
                  end
                  REQ_QUERY: begin
                     if (req_data.first_lit && dirty_cnt_ff != '0) begin
                        state_in = ST_CLR_RD;
                     end else begin
                        state_in = ST_Q_START;
                     end
                  end
                  REQ_READ: state_in = ST_PROOF_RD;
                  default:  state_in = ST_RESP;
               endcase
            end
         end
         ST_ADD_RD0: state_in = ST_ADD_WR0;
         ST_ADD_WR0: state_in = ST_ADD_RD1;
         ST_ADD_RD1: state_in = ST_ADD_WR1;
         ST_ADD_WR1: state_in = ST_RESP;
         ST_CLR_RD:  state_in = ST_CLR_WR;
         ST_CLR_WR: begin
            if (clr_idx_ff + CNT_W'(1) == dirty_cnt_ff) begin
               state_in = ST_Q_START;
            end else begin
               state_in = ST_CLR_RD;
            end
         end
         ST_Q_START: state_in = lit_ok(req_ff.lit_a) ? ST_Q_HEAD : ST_Q_NEED;
         ST_Q_HEAD:  state_in = ST_Q_LINK;
         ST_Q_LINK:  state_in = (link_ff == '0) ? ST_Q_NEED : ST_Q_NODE;
         ST_Q_NODE: begin
            if (node_rdata_ff[LINK_W] == !req_ff.lit_a[LIT_W-1]) begin
               state_in = ST_Q_SEEN;
            end else begin
               state_in = ST_Q_LINK;
            end
         end
         ST_Q_SEEN:    state_in = ST_Q_LINK;
         ST_Q_NEED:    state_in = ST_Q_VERD;
         ST_Q_VERD:    state_in = ST_RESP;
         ST_PROOF_RD:  state_in = ST_PROOF_CAP;
         ST_PROOF_CAP: state_in = ST_RESP;
         ST_RESP:      state_in = out_free ? ST_IDLE : ST_RESP;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_in = req_ff;
      init_cnt_in = init_cnt_ff;
      clause_count_in = clause_count_ff;
      pair_count_in = pair_count_ff;
      dirty_cnt_in = dirty_cnt_ff;
      clr_idx_in = clr_idx_ff;
      qsize_in = qsize_ff;
      link_in = link_ff;
      cl_in = cl_ff;
      need_in = need_ff;
      status_in = status_ff;
      cidx_in = cidx_ff;
      verdict_in = verdict_ff;
      vvalid_in = vvalid_ff;
      pentry_in = pentry_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      heads_we = 1'b0;
      heads_waddr = '0;
      heads_wdata = '0;
      heads_raddr = '0;
      node_we = 1'b0;
      node_waddr = '0;
      node_wdata = '0;
      node_raddr = '0;
      seen_we = 1'b0;
      seen_waddr = '0;
      seen_wdata = 1'b0;
      seen_raddr = '0;
      dirty_we = 1'b0;
      dirty_waddr = '0;
      dirty_wdata = '0;
      dirty_raddr = '0;
      proof_we = 1'b0;
      proof_waddr = '0;
      proof_wdata = '0;
      proof_raddr = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_INIT: begin
            init_cnt_in = init_cnt_ff + CNT_W'(1);
            seen_we = 1'b1;
            seen_waddr = init_cnt_ff[CL_W-1:0];
            if (init_cnt_ff < CNT_W'(VAR_COUNT)) begin
               heads_we = 1'b1;
               heads_waddr = init_cnt_ff[VAR_W-1:0];
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               status_in = STAT_OK;
               cidx_in = '0;
               verdict_in = '0;
               vvalid_in = 1'b0;
               pentry_in = '0;
               if (req_code_type'(req_data.req_type) == REQ_ADD &&
                   clause_count_ff >= CNT_W'(CLAUSE_CAP)) begin
                  status_in = STAT_FULL;
               end
               if (req_code_type'(req_data.req_type) == REQ_QUERY && req_data.first_lit) begin
                  pair_count_in = '0;
                  qsize_in = '0;
                  clr_idx_in = '0;
               end
            end
         end
         ST_ADD_RD0: heads_raddr = lit_var(req_ff.lit_a);
         ST_ADD_WR0: begin
            node_we = 1'b1;
            node_waddr = node0;
            node_wdata = {cur_clause, !req_ff.lit_a[LIT_W-1], heads_rdata_ff};
            heads_we = 1'b1;
            heads_waddr = lit_var(req_ff.lit_a);
            heads_wdata = LINK_W'(node0) + LINK_W'(1);
         end
         ST_ADD_RD1: heads_raddr = lit_var(req_ff.lit_b);
         ST_ADD_WR1: begin
            node_we = 1'b1;
            node_waddr = node1;
            node_wdata = {cur_clause, !req_ff.lit_b[LIT_W-1], heads_rdata_ff};
            heads_we = 1'b1;
            heads_waddr = lit_var(req_ff.lit_b);
            heads_wdata = LINK_W'(node1) + LINK_W'(1);
            cidx_in = cur_clause;
            clause_count_in = clause_count_ff + CNT_W'(1);
         end
         ST_CLR_RD: dirty_raddr = clr_idx_ff[CL_W-1:0];
         ST_CLR_WR: begin
            seen_we = 1'b1;
            seen_waddr = dirty_rdata_ff;
            clr_idx_in = clr_idx_ff + CNT_W'(1);
            if (clr_idx_ff + CNT_W'(1) == dirty_cnt_ff) begin
               dirty_cnt_in = '0;
            end
         end
         ST_Q_START: begin
            if (qsize_ff < QSIZE_W'(QSIZE_MAX)) begin
               qsize_in = qsize_ff + QSIZE_W'(1);
            end
            heads_raddr = lit_var(req_ff.lit_a);
         end
         ST_Q_HEAD: link_in = heads_rdata_ff;
         ST_Q_LINK: begin
            node_raddr = NODE_W'(link_ff - LINK_W'(1));
         end
         ST_Q_NODE: begin
            link_in = node_rdata_ff[LINK_W-1:0];
            cl_in = node_rdata_ff[NDATA_W-1 -: CL_W];
            seen_raddr = node_rdata_ff[NDATA_W-1 -: CL_W];
         end
         ST_Q_SEEN: begin
            if (seen_rdata_ff) begin
               if (pair_count_ff < CNT_W'(CLAUSE_CAP)) begin
                  proof_we = 1'b1;
                  proof_waddr = pair_count_ff[CL_W-1:0];
                  proof_wdata = cl_ff;
                  pair_count_in = pair_count_ff + CNT_W'(1);
               end else begin
                  status_in = STAT_SAT;
               end
            end else begin
               seen_we = 1'b1;
               seen_waddr = cl_ff;
               seen_wdata = 1'b1;
               dirty_we = 1'b1;
               dirty_waddr = dirty_cnt_ff[CL_W-1:0];
               dirty_wdata = cl_ff;
               dirty_cnt_in = dirty_cnt_ff + CNT_W'(1);
            end
         end
         ST_Q_NEED: need_in = need_prod >> 1;
         ST_Q_VERD: begin
            if (req_ff.last_lit) begin
               vvalid_in = 1'b1;
               if (qsize_ff > QSIZE_W'(1) && NEED_W'(pair_count_ff) >= need_ff) begin
                  verdict_in = pair_count_ff;
               end
            end
         end
         ST_PROOF_RD:  proof_raddr = req_ff.proof_index;
         ST_PROOF_CAP: pentry_in = proof_rdata_ff;
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.status = status_ff;
               rsp_data_in.clause_index = cidx_ff;
               rsp_data_in.verdict_count = verdict_ff;
               rsp_data_in.verdict_valid = vvalid_ff;
               rsp_data_in.proof_entry = pentry_ff;
               rsp_data_in.proof_total = pair_count_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
         init_cnt_ff <= '0;
         clause_count_ff <= '0;
         pair_count_ff <= '0;
         dirty_cnt_ff <= '0;
         qsize_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         init_cnt_ff <= init_cnt_in;
         clause_count_ff <= clause_count_in;
         pair_count_ff <= pair_count_in;
         dirty_cnt_ff <= dirty_cnt_in;
         qsize_ff <= qsize_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      clr_idx_ff <= clr_idx_in;
      link_ff <= link_in;
      cl_ff <= cl_in;
      need_ff <= need_in;
      status_ff <= status_in;
      cidx_ff <= cidx_in;
      verdict_ff <= verdict_in;
      vvalid_ff <= vvalid_in;
      pentry_ff <= pentry_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (heads_we) begin
         heads_mem[heads_waddr] <= heads_wdata;
      end
      heads_rdata_ff <= heads_mem[heads_raddr];
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= node_wdata;
      end
      node_rdata_ff <= node_mem[node_raddr];
   end

   always_ff @(posedge clock) begin
      if (seen_we) begin
         seen_mem[seen_waddr] <= seen_wdata;
      end
      seen_rdata_ff <= seen_mem[seen_raddr];
   end

   always_ff @(posedge clock) begin
      if (dirty_we) begin
         dirty_mem[dirty_waddr] <= dirty_wdata;
      end
      dirty_rdata_ff <= dirty_mem[dirty_raddr];
   end

   always_ff @(posedge clock) begin
      if (proof_we) begin
         proof_mem[proof_waddr] <= proof_wdata;
      end
      proof_rdata_ff <= proof_mem[proof_raddr];
   end

   `ECD_ASSERT_ALWAYS(a_clause_bound, clock, reset, clause_count_ff <= CNT_W'(CLAUSE_CAP))
   `ECD_ASSERT_ALWAYS(a_pair_bound, clock, reset, pair_count_ff <= CNT_W'(CLAUSE_CAP))
   `ECD_ASSERT_ALWAYS(a_marks_bound, clock, reset, dirty_cnt_ff <= clause_count_ff)
   `ECD_ASSERT_NEXT(a_mark, clock, reset, mark_set, dirty_cnt_ff == $past(dirty_cnt_ff) + CNT_W'(1))

endmodule
